/* src/apm_pkg.sv */
package apm_pkg;

  localparam int WINDOW      = 10;
  localparam int SAMPLE_BITS = 12;

  localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW);
  localparam int FILL_BITS = $clog2(WINDOW + 1);
  localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(WINDOW);
  localparam logic [SUM_BITS-1:0]  SUM_MAX   = SUM_BITS'(WINDOW * ((2 ** SAMPLE_BITS) - 1));

  // The window average is the sum times a rounded-up reciprocal of WINDOW,
  // shifted right. The shift gives exact truncated quotients for every sum.
  localparam int DIV_SHIFT = SUM_BITS + $clog2(WINDOW);
  localparam int MULT_BITS = SUM_BITS + 1;
  localparam logic [MULT_BITS-1:0] DIV_MULT =
      MULT_BITS'(((2 ** DIV_SHIFT) + WINDOW - 1) / WINDOW);

  localparam int THRESH_BITS = 12;
  localparam int VOLUME_BITS = 16;
  localparam int TOTAL_BITS  = 32;

  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_ADDR_BITS-1:0] REG_HIGH_THRESHOLD   = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_LOW_THRESHOLD    = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_VOLUME_PER_PULSE = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_NORMALLY_CLOSED  = 2'd3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_PRESET = 1'b1;

  typedef struct packed {
    logic                   opcode;
    logic [SAMPLE_BITS-1:0] sample;
    logic [TOTAL_BITS-1:0]  preset_total;
  } item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average;
    logic                   pulse;
    logic [TOTAL_BITS-1:0]  total;
    logic [TOTAL_BITS-1:0]  pulse_count;
    logic                   mismatch;
    logic                   primed;
  } result_t;

  typedef struct packed {
    logic [THRESH_BITS-1:0] high_threshold;
    logic [THRESH_BITS-1:0] low_threshold;
    logic [VOLUME_BITS-1:0] volume_per_pulse;
    logic                   normally_closed;
  } cfg_t;

  // Window state as seen by the transaction in the first stage.
  typedef struct packed {
    logic [SUM_BITS-1:0] sum;
    logic                arm_now;
    logic                hyst;
    logic                primed;
  } win_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average;
    logic                   pulse;
    logic [TOTAL_BITS-1:0]  total;
    logic [TOTAL_BITS-1:0]  pulses;
    logic [TOTAL_BITS-1:0]  base;
    logic                   primed;
  } meter_t;

endpackage

/* src/averaged_pulse_meter.sv */
// Pulse meter on averaged sensor samples. Each transaction is either a new
// sample or a preset of the litre total, and each gives exactly one result.
// One transaction is accepted per clock cycle while item_stall is low, and it
// passes through a four-stage pipeline: the window shift chain and running
// sum, the average and hysteresis stage, the volume multiply, and the mismatch
// compare in the output register. Stages empty themselves independently, so
// up to four transactions are held while the output is stalled. The window is
// a chain of ten sample cells. Configuration registers are to be written by the
// user only while no transaction is in flight; the block does not enforce it.
module averaged_pulse_meter
  import apm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  item_t                    item,
  output logic                     result_valid,
  input  logic                     result_stall,
  output result_t                  result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t cfg;

  logic v1;
  logic v2;
  logic v3;
  logic ld1;
  logic ld2;
  logic ld3;
  logic ld4;

  logic                  s1_opcode;
  logic [TOTAL_BITS-1:0] s1_preset;
  win_t                  win;
  meter_t                meter;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_threshold   <= THRESH_BITS'(2048);
      cfg.low_threshold    <= THRESH_BITS'(1024);
      cfg.volume_per_pulse <= VOLUME_BITS'(100);
      cfg.normally_closed  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_HIGH_THRESHOLD:   cfg.high_threshold   <= cfg_data[THRESH_BITS-1:0];
        REG_LOW_THRESHOLD:    cfg.low_threshold    <= cfg_data[THRESH_BITS-1:0];
        REG_VOLUME_PER_PULSE: cfg.volume_per_pulse <= cfg_data[VOLUME_BITS-1:0];
        REG_NORMALLY_CLOSED:  cfg.normally_closed  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its transaction moves on in this cycle.
  assign ld4 = v3 && (!result_valid || !result_stall);
  assign ld3 = v2 && (!v3 || ld4);
  assign ld2 = v1 && (!v2 || ld3);
  assign ld1 = item_valid && (!v1 || ld2);

  assign item_stall = v1 && !ld2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      v1           <= ld1 || (v1 && !ld2);
      v2           <= ld2 || (v2 && !ld3);
      v3           <= ld3 || (v3 && !ld4);
      result_valid <= ld4 || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_opcode <= item.opcode;
      s1_preset <= item.preset_total;
    end
  end

  apm_window u_window (
    .clk       (clk),
    .rst       (rst),
    .load      (ld1),
    .is_sample (item.opcode == OP_SAMPLE),
    .sample    (item.sample),
    .status    (win)
  );

  apm_meter u_meter (
    .clk          (clk),
    .rst          (rst),
    .load         (ld2),
    .opcode       (s1_opcode),
    .preset_total (s1_preset),
    .win          (win),
    .cfg          (cfg),
    .res          (meter)
  );

  apm_check u_check (
    .clk      (clk),
    .load_mul (ld3),
    .load_out (ld4),
    .m        (meter),
    .volume   (cfg.volume_per_pulse),
    .result   (result)
  );

  a_full_stalls : assert property (@(posedge clk) disable iff (rst)
      (v1 && v2 && v3 && result_valid && result_stall) |-> item_stall)
    else $error("transaction accepted while every stage is blocked");

endmodule

/* src/apm_cell.sv */
module apm_cell
  import apm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   shift,
  input  logic [SAMPLE_BITS-1:0] d,
  output logic [SAMPLE_BITS-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

/* src/apm_window.sv */
module apm_window
  import apm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic                   is_sample,
  input  logic [SAMPLE_BITS-1:0] sample,
  output win_t                   status
);

  logic [SAMPLE_BITS-1:0] tap [WINDOW];
  logic                   shift;
  logic [SUM_BITS-1:0]    sum;
  logic [SUM_BITS-1:0]    sum_next;
  logic [FILL_BITS-1:0]   fill;
  logic                   arm_now;
  logic                   hyst;

  assign shift = load && is_sample;

  // The last cell holds the oldest sample, which leaves the window on a shift.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      apm_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(sample), .q(tap[i]));
    end else begin : g_body
      apm_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(tap[i-1]), .q(tap[i]));
    end
  end

  assign sum_next = sum - SUM_BITS'(tap[WINDOW-1]) + SUM_BITS'(sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum     <= '0;
      fill    <= '0;
      arm_now <= 1'b0;
      hyst    <= 1'b0;
    end else if (load) begin
      arm_now <= is_sample && (fill == FILL_FULL - FILL_BITS'(1));
      hyst    <= is_sample && (fill == FILL_FULL);
      if (is_sample) begin
        sum <= sum_next;
        if (fill != FILL_FULL) begin
          fill <= fill + FILL_BITS'(1);
        end
      end
    end
  end

  assign status.sum     = sum;
  assign status.arm_now = arm_now;
  assign status.hyst    = hyst;
  assign status.primed  = (fill == FILL_FULL);

  a_sum_bound : assert property (@(posedge clk) disable iff (rst) sum <= SUM_MAX)
    else $error("window sum above its largest possible value");

endmodule

/* src/apm_meter.sv */
module apm_meter
  import apm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  opcode,
  input  logic [TOTAL_BITS-1:0] preset_total,
  input  win_t                  win,
  input  cfg_t                  cfg,
  output meter_t                res
);

  logic [SUM_BITS+MULT_BITS-1:0] scaled;
  logic [SAMPLE_BITS-1:0]        avg_next;
  logic                          above;
  logic                          below;
  logic                          fire;
  logic                          release_ok;

  logic                   armed;
  logic [SAMPLE_BITS-1:0] average;
  logic                   pulse;
  logic [TOTAL_BITS-1:0]  total;
  logic [TOTAL_BITS-1:0]  pulses;
  logic [TOTAL_BITS-1:0]  base;
  logic                   primed;

  assign scaled   = (SUM_BITS+MULT_BITS)'(win.sum) * (SUM_BITS+MULT_BITS)'(DIV_MULT);
  assign avg_next = scaled[DIV_SHIFT +: SAMPLE_BITS];

  assign above = SAMPLE_BITS'(avg_next) > cfg.high_threshold;
  assign below = SAMPLE_BITS'(avg_next) < cfg.low_threshold;

  // In normally-closed mode the roles of the two thresholds swap.
  assign fire       = cfg.normally_closed ? below : above;
  assign release_ok = cfg.normally_closed ? above : below;

  always_ff @(posedge clk) begin
    if (rst) begin
      armed   <= 1'b0;
      pulse   <= 1'b0;
      primed  <= 1'b0;
      total   <= '0;
      pulses  <= '0;
      base    <= '0;
      average <= '0;
    end else if (load) begin
      average <= avg_next;
      primed  <= win.primed;
      pulse   <= 1'b0;
      if (opcode == OP_PRESET) begin
        total  <= preset_total;
        base   <= preset_total;
        pulses <= '0;
      end else if (win.arm_now) begin
        armed <= fire;
      end else if (win.hyst) begin
        if (fire && !armed) begin
          armed  <= 1'b1;
          pulse  <= 1'b1;
          pulses <= pulses + TOTAL_BITS'(1);
          total  <= total + TOTAL_BITS'(cfg.volume_per_pulse);
        end else if (release_ok && armed) begin
          armed <= 1'b0;
        end
      end
    end
  end

  assign res.average = average;
  assign res.pulse   = pulse;
  assign res.total   = total;
  assign res.pulses  = pulses;
  assign res.base    = base;
  assign res.primed  = primed;

  a_pulse_armed : assert property (@(posedge clk) disable iff (rst) pulse |-> armed)
    else $error("pulse counted without the arm flag set");

  a_pulse_primed : assert property (@(posedge clk) disable iff (rst) pulse |-> primed)
    else $error("pulse counted before the window was full");

endmodule

/* src/apm_check.sv */
module apm_check
  import apm_pkg::*;
(
  input  logic                   clk,
  input  logic                   load_mul,
  input  logic                   load_out,
  input  meter_t                 m,
  input  logic [VOLUME_BITS-1:0] volume,
  output result_t                result
);

  logic [TOTAL_BITS+VOLUME_BITS-1:0] product;
  meter_t                            m_mul;
  logic [TOTAL_BITS-1:0]             expected;

  assign product = (TOTAL_BITS+VOLUME_BITS)'(m.pulses)
                 * (TOTAL_BITS+VOLUME_BITS)'(volume);

  always_ff @(posedge clk) begin
    if (load_mul) begin
      m_mul    <= m;
      expected <= product[TOTAL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.average     <= m_mul.average;
      result.pulse       <= m_mul.pulse;
      result.total       <= m_mul.total;
      result.pulse_count <= m_mul.pulses;
      result.mismatch    <= (m_mul.base + expected) != m_mul.total;
      result.primed      <= m_mul.primed;
    end
  end

endmodule

/* bench/averaged_pulse_meter_tb.sv */
`timescale 1ns / 100ps

module averaged_pulse_meter_tb;
  import apm_pkg::*;

  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 136;
  localparam int NUM_PHASES    = 9;
  localparam int HOLD_PHASE    = 4;

  // Idle modes: none, sender idles, receiver stalls, both.
  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SENDER   = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH     = 3;

  // Threshold pairs include crossed thresholds and both extremes, and the
  // mode flips between most phases while the arm flag carries over.
  localparam cfg_t PLANS [NUM_PHASES] = '{
    '{12'd2048, 12'd1024, 16'd100,   1'b0},
    '{12'd3000, 12'd1000, 16'd65535, 1'b1},
    '{12'd1500, 12'd2500, 16'd7,     1'b0},
    '{12'd1500, 12'd2500, 16'd300,   1'b1},
    '{12'd4095, 12'd0,    16'd0,     1'b0},
    '{12'd0,    12'd4095, 16'd1,     1'b1},
    '{12'd0,    12'd0,    16'd65535, 1'b0},
    '{12'd2600, 12'd1400, 16'd1234,  1'b1},
    '{12'd4095, 12'd4095, 16'd0,     1'b1}
  };

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     item_valid = 1'b0;
  logic                     item_stall;
  item_t                    item = '0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  result_t                  result;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Meter state as the predictor sees it.
  logic [SAMPLE_BITS-1:0] win_q [WINDOW] = '{default: '0};
  int unsigned            win_sum = 0;
  int unsigned            fill = 0;
  int unsigned            wpos = 0;
  bit                     armed_q = 1'b0;
  logic [31:0]            total_q = '0;
  logic [31:0]            pulses_q = '0;
  logic [31:0]            base_q = '0;
  logic [11:0]            hi_q = 12'd2048;
  logic [11:0]            lo_q = 12'd1024;
  logic [15:0]            vol_q = 16'd100;
  bit                     nc_q = 1'b0;

  result_t  expected_readings [$];
  result_t  head;
  dir_row_t directed [$];
  int       errors = 0;
  int       idle_mode = IDLE_NONE;
  int       hold_left = 0;
  int       hold_requests = 0;
  int       hold_served = 0;
  int       level = 0;
  int       run_left = 0;

  averaged_pulse_meter DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic result_t meter_predict(item_t it);
    result_t     r;
    logic [11:0] avg;
    bit          fire;
    bit          drop;
    r = '0;
    if (it.opcode == OP_PRESET) begin
      total_q  = it.preset_total;
      base_q   = it.preset_total;
      pulses_q = '0;
    end else begin
      win_sum     = win_sum - win_q[wpos] + it.sample;
      win_q[wpos] = it.sample;
      wpos        = (wpos == WINDOW - 1) ? 0 : wpos + 1;
      avg         = 12'(win_sum / WINDOW);
      if (fill < WINDOW) begin
        fill++;
        // The sample that fills the window only sets the arm flag.
        if (fill == WINDOW) armed_q = nc_q ? (avg < lo_q) : (avg > hi_q);
      end else begin
        fire = nc_q ? (avg < lo_q) : (avg > hi_q);
        drop = nc_q ? (avg > hi_q) : (avg < lo_q);
        if (fire && !armed_q) begin
          armed_q  = 1'b1;
          r.pulse  = 1'b1;
          pulses_q = pulses_q + 1;
          total_q  = total_q + 32'(vol_q);
        end else if (drop && armed_q) begin
          armed_q = 1'b0;
        end
      end
    end
    r.average     = 12'(win_sum / WINDOW);
    r.total       = total_q;
    r.pulse_count = pulses_q;
    r.mismatch    = (base_q + pulses_q * 32'(vol_q)) != total_q;
    r.primed      = fill >= WINDOW;
    return r;
  endfunction

  // Most samples follow a level held for a short run, so the average swings
  // across both thresholds; the rest are presets and raw noise.
  function automatic item_t next_reading();
    item_t it;
    int    v;
    it.opcode       = OP_SAMPLE;
    it.sample       = 12'($urandom);
    it.preset_total = $urandom;
    if (roll(6)) begin
      it.opcode = OP_PRESET;
      case ($urandom_range(2))
        0: it.preset_total = 32'hFFFF_FFFF - $urandom_range(300);
        1: it.preset_total = $urandom_range(300);
        default: ;
      endcase
    end else if (!roll(8)) begin
      if (run_left == 0) begin
        case ($urandom_range(2))
          0: level = $urandom_range(400);
          1: level = 4095 - $urandom_range(400);
          default: level = $urandom_range(4095);
        endcase
        run_left = $urandom_range(14, 3);
      end
      run_left--;
      v = level + int'($urandom_range(200)) - 100;
      it.sample = (v < 0) ? 12'd0 : (v > 4095) ? 12'hFFF : 12'(v);
    end
    return it;
  endfunction

  task automatic send(item_t it, bit typed, result_t want);
    result_t predicted;
    while (roll(idle_mode == IDLE_SENDER ? 61 : idle_mode == IDLE_BOTH ? 15 : 0)) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    predicted = meter_predict(it);
    expected_readings.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(logic [CFG_ADDR_BITS-1:0] addr, logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(cfg_t c);
    write_reg(REG_HIGH_THRESHOLD, 16'(c.high_threshold));
    write_reg(REG_LOW_THRESHOLD, 16'(c.low_threshold));
    write_reg(REG_VOLUME_PER_PULSE, c.volume_per_pulse);
    write_reg(REG_NORMALLY_CLOSED, 16'(c.normally_closed));
    cfg_valid <= 1'b0;
    hi_q  = c.high_threshold;
    lo_q  = c.low_threshold;
    vol_q = c.volume_per_pulse;
    nc_q  = c.normally_closed;
  endtask

  task automatic drain();
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // A long hold is counted here, so the block fills and stalls its input.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served  <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= roll(idle_mode == IDLE_RECEIVER ? 61 : idle_mode == IDLE_BOTH ? 15 : 0);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && !result_stall) begin
      if (expected_readings.size() == 0) begin
        $error("result transaction with no reading expected");
        errors++;
      end else begin
        head = expected_readings.pop_front();
        check_field("average", 32'(head.average), 32'(result.average));
        check_field("pulse", 32'(head.pulse), 32'(result.pulse));
        check_field("total", head.total, result.total);
        check_field("pulse_count", head.pulse_count, result.pulse_count);
        check_field("mismatch", 32'(head.mismatch), 32'(result.mismatch));
        check_field("primed", 32'(head.primed), 32'(result.primed));
      end
    end
  end

  initial begin
    // Preset to the top of the range, fill the window high so it arms,
    // drop below low to release, then rise again: the pulse wraps the total.
    directed.push_back('{'{OP_PRESET, 12'd0, 32'hFFFF_FFFF}, 1'b1,
                         '{12'd0, 1'b0, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0}});
    directed.push_back('{'{OP_SAMPLE, 12'hFFF, 32'd0}, 1'b1,
                         '{12'd409, 1'b0, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0}});
    repeat (9) directed.push_back('{'{OP_SAMPLE, 12'hFFF, 32'hFFFF_FFFF}, 1'b0, '0});
    repeat (8) directed.push_back('{'{OP_SAMPLE, 12'd0, 32'hFFFF_FFFF}, 1'b0, '0});
    repeat (6) directed.push_back('{'{OP_SAMPLE, 12'hFFF, 32'd0}, 1'b0, '0});

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send(directed[i].stim, directed[i].typed, directed[i].want);
    item_valid <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      load_settings(PLANS[p]);
      idle_mode = p % 4;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == HOLD_PHASE && n == 30) hold_requests++;
        send(next_reading(), 1'b0, '0);
      end
      item_valid <= 1'b0;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
